// ===== rtl/indexed_list_insert_remove_assert.svh =====
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ILIR_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILIR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/ilir_pkg.sv =====
// Shared types and codes for the indexed list block.
package ilir_pkg;

    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 40;

endpackage

// ===== rtl/ilir_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
module ilir_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
// Top level: fixed-capacity ordered list of signed words with insert and remove at an index.
// tvalid rises when S_FIN posts the result to a free output. Read, overwrite, append, clear, spare
// codes and rejected requests go from S_IDLE to S_FIN; insert at i below the count shifts entries
// up in S_SHIFT_UP, one entry per cycle, then writes in S_PUT; remove below the last entry shifts down in S_SHIFT_DN.
// One request at a time; the next is taken in the cycle after the result is posted, even while it waits.
// Reset clears the count and the handshake state; stored entries stay undefined until written.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,   // operation[2:0], index[7:3], value[39:8]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata    // read_value[31:0], status[33:32],
                                           // fill_count[38:34], is_empty[39]
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = CNT_W + 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_FIN
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]     pos_reg;
    logic [WORD_BITS-1:0]  val_reg;
    logic [1:0]            st_reg;
    logic                  rd_flag_reg;
    logic                  m_tvalid_reg;
    logic [OUT_BITS-1:0]   m_tdata_reg;

    logic                  accept;
    op_t                   op;
    logic [4:0]            in_index;
    logic [WORD_BITS-1:0]  in_word;
    logic [CW-1:0]         idx_w;
    logic [CW-1:0]         cnt_w;
    logic                  idx_lt;
    logic                  idx_le;
    logic                  full;
    logic                  out_free;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic [31:0]           rd_out;
    logic [4:0]            cnt_out;

    assign op       = op_t'(s_tdata[2:0]);
    assign in_index = s_tdata[7:3];
    assign in_word  = WORD_BITS'(signed'(s_tdata[39:8]));
    assign idx_w    = CW'(in_index);
    assign cnt_w    = CW'(count_reg);
    assign idx_lt   = idx_w < cnt_w;
    assign idx_le   = idx_w <= cnt_w;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(in_index);
        ram_wdata = in_word;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(in_index);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_READ:
                        begin
                            ram_re = idx_lt;
                        end
                        OP_WRITE:
                        begin
                            ram_we = idx_lt;
                        end
                        OP_APPEND:
                        begin
                            ram_we    = !full;
                            ram_waddr = ADDR_W'(count_reg);
                        end
                        OP_INSERT:
                        begin
                            if (idx_le && !full)
                            begin
                                if (idx_w == cnt_w)
                                begin
                                    ram_we = 1'b1;
                                end
                                else
                                begin
                                    ram_re    = 1'b1;
                                    ram_raddr = ADDR_W'(cnt_w - CW'(1));
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_lt && (idx_w + CW'(1) != cnt_w))
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(idx_w + CW'(1));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                if (pos_reg - ADDR_W'(1) != idx_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_reg - ADDR_W'(2);
                end
            end
            S_SHIFT_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                if (CW'(pos_reg) + CW'(1) < cnt_w)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(CW'(pos_reg) + CW'(2));
                end
            end
            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = val_reg;
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    ilir_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_out  = rd_flag_reg ? 32'(signed'(ram_rdata)) : 32'd0;
    assign cnt_out = 5'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= ADDR_W'(in_index);
                        val_reg <= in_word;
                        unique case (op)
                            OP_READ:
                            begin
                                st_reg      <= idx_lt ? ST_OK : ST_RANGE;
                                rd_flag_reg <= idx_lt;
                                state_reg   <= S_FIN;
                            end
                            OP_WRITE:
                            begin
                                st_reg      <= idx_lt ? ST_OK : ST_RANGE;
                                rd_flag_reg <= 1'b0;
                                state_reg   <= S_FIN;
                            end
                            OP_APPEND:
                            begin
                                st_reg      <= full ? ST_FULL : ST_OK;
                                rd_flag_reg <= 1'b0;
                                state_reg   <= S_FIN;
                                if (!full)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_INSERT:
                            begin
                                rd_flag_reg <= 1'b0;
                                if (!idx_le)
                                begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_FIN;
                                end
                                else if (full)
                                begin
                                    st_reg    <= ST_FULL;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    st_reg    <= ST_OK;
                                    count_reg <= count_reg + CNT_W'(1);
                                    pos_reg   <= ADDR_W'(count_reg);
                                    state_reg <= (idx_w != cnt_w) ? S_SHIFT_UP : S_FIN;
                                end
                            end
                            OP_REMOVE:
                            begin
                                rd_flag_reg <= 1'b0;
                                if (!idx_lt)
                                begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_FIN;
                                end
                                else
                                begin
                                    st_reg    <= ST_OK;
                                    count_reg <= count_reg - CNT_W'(1);
                                    pos_reg   <= ADDR_W'(in_index);
                                    state_reg <= (idx_w + CW'(1) != cnt_w) ? S_SHIFT_DN : S_FIN;
                                end
                            end
                            OP_CLEAR:
                            begin
                                st_reg      <= ST_OK;
                                rd_flag_reg <= 1'b0;
                                state_reg   <= S_FIN;
                                count_reg   <= '0;
                            end
                            default:
                            begin
                                st_reg      <= ST_OK;
                                rd_flag_reg <= 1'b0;
                                state_reg   <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SHIFT_UP:
                begin
                    pos_reg <= pos_reg - ADDR_W'(1);
                    if (pos_reg - ADDR_W'(1) == idx_reg)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_SHIFT_DN:
                begin
                    pos_reg <= pos_reg + ADDR_W'(1);
                    if (CW'(pos_reg) + CW'(1) >= cnt_w)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_PUT:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg <= {(count_reg == '0), cnt_out, st_reg, rd_out};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/ilir_checker.sv =====
// Port-level checker for the indexed list block, bound to the top level.
`include "indexed_list_insert_remove_assert.svh"

module ilir_checker
    import ilir_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [IN_BITS-1:0]  s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    logic [31:0] rd_val;
    logic [1:0]  st;
    logic [4:0]  cnt;
    logic        empty;

    assign rd_val = m_tdata[31:0];
    assign st     = m_tdata[33:32];
    assign cnt    = m_tdata[38:34];
    assign empty  = m_tdata[39];

    `ILIR_ASSERT_NOW(a_empty_flag, m_tvalid, empty == (cnt == 5'd0), "empty flag disagrees with count")
    `ILIR_ASSERT_NOW(a_status_code, m_tvalid, st == ST_OK || st == ST_RANGE || st == ST_FULL, "bad status code")
    `ILIR_ASSERT_NOW(a_read_zero, m_tvalid && st != ST_OK, rd_val == 32'd0, "read value set on a failed request")
    `ILIR_ASSERT_NOW(a_count_cap, m_tvalid && CAPACITY < 32, 32'(cnt) <= 32'(CAPACITY), "count above capacity")
    `ILIR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

endmodule

bind indexed_list_insert_remove ilir_checker #(
    .CAPACITY (CAPACITY)
) u_ilir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/indexed_list_checker.sv =====
// Checker for the indexed list block: predicts the reply to each request and compares it.
module indexed_list_checker
    import ilir_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,   // operation[2:0], index[7:3], value[39:8]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_BITS-1:0] m_tdata,   // read_value[31:0], status[33:32],
                                           // fill_count[38:34], is_empty[39]
    output int                  fail_count,
    output int                  pending,
    output logic [4:0]          list_size
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int MAX_REPORTS = 10;

    // member order gives the tdata layout, is_empty in the top bit
    typedef struct packed {
        logic               is_empty;
        logic [4:0]         fill_count;
        logic [1:0]         status;
        logic signed [31:0] read_value;
    } list_reply_t;

    logic signed [31:0] shadow_words [DEPTH];
    int                 shadow_count;
    list_reply_t        reply_q [$];
    int                 errors;

    function automatic list_reply_t apply_request(input logic [2:0] op, input logic [4:0] idx,
                                                  input logic signed [31:0] val);
        list_reply_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_READ:
                if (idx >= shadow_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow_words[idx];
            OP_WRITE:
                if (idx >= shadow_count)
                    r.status = ST_RANGE;
                else
                    shadow_words[idx] = val;
            OP_APPEND:
                if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = val;
                    shadow_count++;
                end
            OP_INSERT:
                if (idx > shadow_count)
                    r.status = ST_RANGE;
                else if (shadow_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > idx; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[idx] = val;
                    shadow_count++;
                end
            OP_REMOVE:
                if (idx >= shadow_count)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = idx; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                end
            OP_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        r.fill_count = shadow_count[4:0];
        r.is_empty   = (shadow_count == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_reply_t got;
        list_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                shadow_words[i] = '0;
            shadow_count = 0;
            reply_q.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
            list_size  <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = list_reply_t'(m_tdata);
                if (reply_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: reply with no request waiting: %h", $realtime, m_tdata);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.fill_count !== want.fill_count || got.is_empty !== want.is_empty)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: reply mismatch: expected value %0d status %0d ",
                                      "count %0d empty %0b, got value %0d status %0d ",
                                      "count %0d empty %0b"}, $realtime,
                                     want.read_value, want.status, want.fill_count,
                                     want.is_empty, got.read_value, got.status,
                                     got.fill_count, got.is_empty);
                    end
                end
            end
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_request(s_tdata[2:0], s_tdata[7:3], s_tdata[39:8]));
            fail_count <= errors;
            pending    <= reply_q.size();
            list_size  <= shadow_count[4:0];
        end
    end

endmodule

// ===== tb/tb_indexed_list_insert_remove.sv =====
// Testbench top for the indexed list block: drives requests, takes replies, gives the verdict.
module tb_indexed_list_insert_remove;
    timeunit 1ns;
    timeprecision 1ps;
    import ilir_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int CAPACITY        = 16;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int MAX_GAP         = 17;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 40;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;   // operation[2:0], index[7:3], value[39:8]
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;   // read_value[31:0], status[33:32],
                                    // fill_count[38:34], is_empty[39]
    int                  fail_count;
    int                  pending;
    logic [4:0]          list_size;
    int                  idle_cycles;
    bit                  source_quiet;
    bit                  sink_quiet;
    bit                  filling;

    indexed_list_insert_remove dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    indexed_list_checker list_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .list_size  (list_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // reply side: random stall before each reply, with quiet stretches
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) < 3)
                sink_quiet = !sink_quiet;
            gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // leaves the caller at the falling edge where the next request goes out
    task automatic hold_off();
        int gap;
        gap = source_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
    endtask

    task automatic present(input logic [2:0] op, input logic [4:0] idx, input logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {val, idx, op};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_request(input logic [2:0] op, input logic [4:0] idx,
                                input logic [31:0] val);
        hold_off();
        present(op, idx, val);
    endtask

    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_random_request();
        logic [2:0]  op;
        logic [4:0]  idx;
        logic [31:0] val;
        int          pick;
        int          count;
        int          top_index;
        hold_off();
        count = list_size;
        if (count == CAPACITY && $urandom_range(0, 5) == 0)
            filling = 1'b0;
        else if (count == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 99) < 2)
            filling = !filling;

        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        else if (pick < 3)
            op = OP_CLEAR;
        else if (pick < 20)
            op = OP_READ;
        else if (pick < 34)
            op = OP_WRITE;
        else if (pick < 68)
            op = !filling ? OP_REMOVE : ($urandom_range(0, 1) ? OP_APPEND : OP_INSERT);
        else if (pick < 84)
            op = OP_INSERT;
        else
            op = OP_REMOVE;

        top_index = (op == OP_INSERT) ? count : count - 1;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            idx = 5'($urandom_range(0, 31));
        else if (pick == 1 || top_index < 0)
            idx = 5'(top_index + 1);
        else
            idx = 5'($urandom_range(0, top_index));

        case ($urandom_range(0, 9))
            0: val = 32'h8000_0000;
            1: val = 32'h7fff_ffff;
            2: val = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
            default: val = $urandom;
        endcase
        present(op, idx, val);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        filling  = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_READ, 5'd0, 32'h0);
        send_request(OP_REMOVE, 5'd0, 32'h0);
        send_request(OP_INSERT, 5'd1, 32'h5555_aaaa);
        send_request(OP_INSERT, 5'd0, 32'h8000_0000);
        send_request(OP_APPEND, 5'd0, 32'h7fff_ffff);
        send_request(OP_INSERT, 5'd1, 32'hffff_ffff);
        send_request(OP_INSERT, 5'd3, 32'h1234_5678);
        send_request(OP_READ, 5'd1, 32'h0);
        send_request(OP_READ, 5'd3, 32'h0);
        send_request(OP_WRITE, 5'd2, 32'h0);
        send_request(OP_READ, 5'd2, 32'h0);
        send_request(OP_REMOVE, 5'd0, 32'h0);
        send_request(OP_READ, 5'd0, 32'h0);
        send_request(OP_WRITE, 5'd31, 32'hdead_beef);
        send_request(OP_REMOVE, 5'd3, 32'h0);
        send_request(OP_SPARE_6, 5'd31, 32'hffff_ffff);
        send_request(OP_SPARE_7, 5'd0, 32'h0);
        send_request(OP_CLEAR, 5'd0, 32'h0);
        send_request(OP_READ, 5'd0, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
            send_request(OP_APPEND, 5'd0, $urandom);
        send_request(OP_APPEND, 5'd0, 32'h1);
        send_request(OP_INSERT, 5'd16, 32'h2);
        send_request(OP_INSERT, 5'd17, 32'h3);
        send_request(OP_INSERT, 5'd0, 32'h4);
        send_request(OP_READ, 5'd15, 32'h0);
        send_request(OP_REMOVE, 5'd15, 32'h0);
        send_request(OP_CLEAR, 5'd0, 32'h0);
        drain_replies();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 99) < 3)
                source_quiet = !source_quiet;
            if (n % 400 == 399)
                drain_replies();
            send_random_request();
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
